>>> hw/rtl/lfu_pkg.sv
// Shared types and constants of the LFU cache replacement block.
package lfu_pkg;

  localparam int unsigned CapBits  = 5;
  localparam int unsigned CapReset = 16;
  localparam int unsigned SizeBits = 9;

  localparam logic OpGet = 1'b0;
  localparam logic OpSet = 1'b1;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } lfu_req_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] read_value;
    logic               evicted;
    logic signed [31:0] evicted_key;
  } lfu_rsp_t;

endpackage

>>> hw/rtl/lfu_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module lfu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/lfu_cache_replacement.sv
// Top level of the LFU cache replacement block with LRU tie break.
// A request item (operation, key, value) enters on the input channel when
// in_valid_i is high and in_stall_o is low. Exactly one response item
// (hit, read value, eviction flag, evicted key) leaves on the output
// channel, which holds it while out_stall_i is high.
// The entries live in one RAM with a registered read port. Every item
// first scans all ENTRIES entries, one per cycle, for a key match, the fill
// level, a free slot and the victim with the lowest use count. An item that
// changes the store then makes a second pass that reads every entry,
// updates the recency ranks and writes back the target and valid entries.
// A get miss or a set at zero capacity makes only the scan pass; every
// other item makes both passes over the single RAM before it responds.
// One item is in work at a time, and a new item may enter while the
// previous response still waits on a stall.
// The capacity register is written through cfg_valid_i and cfg_data_i,
// always ready; the user must write it only while the block is idle, as
// the block itself does not enforce this.
// Reset clears all valid marks, sets the capacity to 16 and empties the
// output register; the RAM contents need no clearing.
module lfu_cache_replacement
  import lfu_pkg::*;
#(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lfu_req_t           in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lfu_rsp_t           out_rsp_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CapBits-1:0] cfg_data_i
);

  localparam int unsigned IW = ENTRIES > 1 ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned EW = 64 + COUNT_BITS + IW;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StUpd  = 2'd2;
  localparam logic [1:0] StDone = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [CapBits-1:0]   cap_q;
  logic [ENTRIES-1:0]   valid_q;
  logic [CW-1:0]        cnt_q;
  logic                 rd_pend_q;
  logic [IW-1:0]        rd_idx_q;
  lfu_req_t             req_q;
  logic [CW-1:0]        fill_q;
  logic                 found_q, slot_ok_q, vic_ok_q;
  logic [IW-1:0]        fidx_q, slot_q, vidx_q;
  logic [31:0]          fval_q, vkey_q;
  logic [COUNT_BITS-1:0] fcnt_q, vcnt_q;
  logic [IW-1:0]        frank_q, vrank_q;
  logic [IW-1:0]        tgt_q;
  logic [EW-1:0]        tgt_data_q;
  logic [IW-1:0]        thr_q;
  logic                 inc_all_q;
  lfu_rsp_t             res_q;
  logic                 out_valid_q;
  lfu_rsp_t             out_rsp_q;

  logic                 issue;
  logic [EW-1:0]        rdata;
  logic [31:0]          e_key, e_val;
  logic [COUNT_BITS-1:0] e_cnt;
  logic [IW-1:0]        e_rank;
  logic                 we;
  logic [EW-1:0]        wdata;
  logic                 pass_end;
  logic [SizeBits-1:0]  eff;
  logic                 load_out;
  logic                 set_off;

  assign issue    = (state_q == StScan || state_q == StUpd) && cnt_q < CW'(ENTRIES);
  assign pass_end = cnt_q == CW'(ENTRIES) && !rd_pend_q;
  assign e_key    = rdata[EW-1 -: 32];
  assign e_val    = rdata[EW-33 -: 32];
  assign e_cnt    = rdata[IW +: COUNT_BITS];
  assign e_rank   = rdata[IW-1:0];
  assign eff      = (SizeBits'(cap_q) > SizeBits'(ENTRIES)) ? SizeBits'(ENTRIES)
                                                           : SizeBits'(cap_q);
  assign load_out = state_q == StDone && (!out_valid_q || !out_stall_i);
  assign set_off  = req_q.operation == OpSet && eff == '0;

  always_comb begin
    we    = 1'b0;
    wdata = rdata;
    if (state_q == StUpd && rd_pend_q) begin
      if (rd_idx_q == tgt_q) begin
        we    = 1'b1;
        wdata = tgt_data_q;
      end else if (valid_q[rd_idx_q]) begin
        we = 1'b1;
        if (inc_all_q || e_rank < thr_q) begin
          wdata[IW-1:0] = e_rank + IW'(1);
        end
      end
    end
  end

  lfu_ram #(
    .WIDTH(EW),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(rd_idx_q),
    .wdata_i(wdata),
    .raddr_i(cnt_q[IW-1:0]),
    .rdata_o(rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (in_valid_i) state_d = StScan;
      StScan:  if (pass_end) state_d = StDone;
      StUpd:   if (pass_end) state_d = StDone;
      StDone:  if (load_out) state_d = StIdle;
      default: state_d = StIdle;
    endcase
    if (state_q == StScan && pass_end && found_q && !set_off) begin
      state_d = StUpd;
    end
    if (state_q == StScan && pass_end && !found_q && req_q.operation == OpSet &&
        eff != '0) begin
      state_d = StUpd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cap_q       <= CapBits'(CapReset);
      valid_q     <= '0;
      cnt_q       <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= issue;
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      if (issue) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pass_end) begin
        cnt_q <= '0;
      end
      if (state_q == StScan && pass_end && !found_q && req_q.operation == OpSet &&
          eff != '0 && SizeBits'(fill_q) < eff) begin
        valid_q[slot_q] <= 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= cnt_q[IW-1:0];
    if (load_out) begin
      out_rsp_q <= res_q;
    end
    if (state_q == StIdle) begin
      req_q     <= in_req_i;
      fill_q    <= '0;
      found_q   <= 1'b0;
      slot_ok_q <= 1'b0;
      vic_ok_q  <= 1'b0;
    end
    if (state_q == StScan && rd_pend_q) begin
      if (valid_q[rd_idx_q]) begin
        fill_q <= fill_q + CW'(1);
        if (!found_q && e_key == req_q.key) begin
          found_q <= 1'b1;
          fidx_q  <= rd_idx_q;
          fval_q  <= e_val;
          fcnt_q  <= e_cnt;
          frank_q <= e_rank;
        end
        if (!vic_ok_q || e_cnt < vcnt_q || (e_cnt == vcnt_q && e_rank > vrank_q)) begin
          vic_ok_q <= 1'b1;
          vidx_q   <= rd_idx_q;
          vkey_q   <= e_key;
          vcnt_q   <= e_cnt;
          vrank_q  <= e_rank;
        end
      end else if (!slot_ok_q) begin
        slot_ok_q <= 1'b1;
        slot_q    <= rd_idx_q;
      end
    end
    if (state_q == StScan && pass_end) begin
      if (found_q && !set_off) begin
        res_q      <= '{hit: 1'b1, read_value: fval_q, evicted: 1'b0, evicted_key: '0};
        inc_all_q  <= 1'b0;
        tgt_q      <= fidx_q;
        thr_q      <= frank_q;
        tgt_data_q <= {req_q.key,
                       (req_q.operation == OpSet) ? req_q.value : fval_q,
                       (fcnt_q == '1) ? fcnt_q : fcnt_q + COUNT_BITS'(1),
                       IW'(0)};
      end else if (req_q.operation == OpSet && eff != '0) begin
        tgt_data_q <= {req_q.key, req_q.value, COUNT_BITS'(0), IW'(0)};
        if (SizeBits'(fill_q) >= eff) begin
          res_q     <= '{hit: 1'b0, read_value: '0, evicted: 1'b1, evicted_key: vkey_q};
          inc_all_q <= 1'b0;
          tgt_q     <= vidx_q;
          thr_q     <= vrank_q;
        end else begin
          res_q     <= '0;
          tgt_q     <= slot_q;
          inc_all_q <= 1'b1;
        end
      end else begin
        res_q     <= '0;
        inc_all_q <= 1'b0;
      end
    end
  end

  assign in_stall_o  = state_q != StIdle;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;
  assign cfg_ready_o = 1'b1;

  assert property (@(posedge clk_i) disable iff (!rst_ni) we |-> state_q == StUpd)
    else $error("RAM written outside the update pass.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> !(res_q.hit && res_q.evicted))
    else $error("Response reports both a hit and an eviction.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDone |=> state_q == StDone || state_q == StIdle)
    else $error("Done state left for a pass.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> state_q == StScan || state_q == StUpd)
    else $error("Pending RAM read outside a pass.");

endmodule

>>> test/lfu_cache_checker.sv
// Checker that predicts and compares the responses of the LFU cache block.
`timescale 1ns / 100ps

module lfu_cache_checker
  import lfu_pkg::*;
#(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  lfu_req_t           in_req_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  lfu_rsp_t           out_rsp_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CapBits-1:0] cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  logic [CapBits-1:0]    model_cap;
  logic                  slot_used [ENTRIES];
  logic [31:0]           slot_key  [ENTRIES];
  logic [31:0]           slot_val  [ENTRIES];
  logic [COUNT_BITS-1:0] slot_uses [ENTRIES];
  int unsigned           slot_age  [ENTRIES];
  lfu_rsp_t              exp_fifo  [16];
  logic [3:0]            exp_wr, exp_rd;

  function automatic lfu_rsp_t lookup_or_insert(lfu_req_t req);
    lfu_rsp_t    rsp;
    int unsigned lim, fill, found, slot, victim, r;
    rsp = '0;
    lim = (model_cap > ENTRIES) ? ENTRIES : model_cap;
    fill = 0;
    found = ENTRIES;
    slot = ENTRIES;
    if (req.operation == OpSet && lim == 0) return rsp;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_used[i]) begin
        fill++;
        if (found == ENTRIES && slot_key[i] == req.key) found = i;
      end else if (slot == ENTRIES) begin
        slot = i;
      end
    end
    if (found < ENTRIES) begin
      rsp.hit = 1'b1;
      rsp.read_value = slot_val[found];
      if (slot_uses[found] != CountMax) slot_uses[found]++;
      r = slot_age[found];
      for (int i = 0; i < ENTRIES; i++)
        if (slot_used[i] && i != found && slot_age[i] < r) slot_age[i]++;
      slot_age[found] = 0;
      if (req.operation == OpSet) slot_val[found] = req.value;
      return rsp;
    end
    if (req.operation == OpGet) return rsp;
    if (fill >= lim) begin
      victim = ENTRIES;
      for (int i = 0; i < ENTRIES; i++) begin
        if (!slot_used[i]) continue;
        if (victim == ENTRIES || slot_uses[i] < slot_uses[victim] ||
            (slot_uses[i] == slot_uses[victim] && slot_age[i] > slot_age[victim]))
          victim = i;
      end
      if (victim < ENTRIES) begin
        r = slot_age[victim];
        rsp.evicted = 1'b1;
        rsp.evicted_key = slot_key[victim];
        slot_used[victim] = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
          if (slot_used[i] && slot_age[i] > r) slot_age[i]--;
        slot = victim;
      end
    end
    if (slot < ENTRIES) begin
      for (int i = 0; i < ENTRIES; i++) if (slot_used[i]) slot_age[i]++;
      slot_used[slot] = 1'b1;
      slot_key[slot] = req.key;
      slot_val[slot] = req.value;
      slot_uses[slot] = '0;
      slot_age[slot] = 0;
    end
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lfu_rsp_t want;
    if (!rst_ni) begin
      model_cap = CapBits'(CapReset);
      for (int i = 0; i < ENTRIES; i++) begin
        slot_used[i] = 1'b0;
        slot_key[i] = '0;
        slot_val[i] = '0;
        slot_uses[i] = '0;
        slot_age[i] = 0;
      end
      exp_wr = '0;
      exp_rd = '0;
      pending_o = 0;
      fail_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_o == 0) begin
          if (fail_count_o < 10) $display("Unexpected response item %p", out_rsp_i);
          fail_count_o++;
        end else begin
          want = exp_fifo[exp_rd];
          exp_rd = exp_rd + 4'd1;
          pending_o--;
          if (out_rsp_i.hit !== want.hit || out_rsp_i.read_value !== want.read_value ||
              out_rsp_i.evicted !== want.evicted ||
              out_rsp_i.evicted_key !== want.evicted_key) begin
            if (fail_count_o < 10)
              $display("Mismatch: expected %p, actual %p", want, out_rsp_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        exp_fifo[exp_wr] = lookup_or_insert(in_req_i);
        exp_wr = exp_wr + 4'd1;
        pending_o++;
      end
      if (cfg_valid_i && cfg_ready_i) model_cap = cfg_data_i;
    end
  end

endmodule

>>> test/tb_lfu_cache_replacement.sv
// Testbench top that drives the LFU cache block and reports the verdict.
`timescale 1ns / 100ps

module tb_lfu_cache_replacement;
  import lfu_pkg::*;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  lfu_req_t           in_req_i;
  logic               out_valid_o;
  logic               out_stall_i;
  lfu_rsp_t           out_rsp_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CapBits-1:0] cfg_data_i;
  int                 fail_count;
  int                 pending;
  logic               hold_off;
  logic               stall_free;
  logic [31:0]        key_pool [8];

  lfu_cache_replacement uut (.*);

  lfu_cache_checker check (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_req_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_rsp_i(out_rsp_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("** lfu_cache_replacement: FAILED **");
    $finish;
  end

  always @(posedge clk_i) begin
    if (hold_off) begin
      out_stall_i <= 1'b1;
    end else if (stall_free) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 3) == 0);
    end
  end

  task automatic send_item(logic op, logic [31:0] key, logic [31:0] value);
    in_valid_i <= 1'b1;
    in_req_i <= '{operation: op, key: key, value: value};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic pause_sender();
    in_valid_i <= 1'b0;
    repeat ($urandom_range(1, 40)) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [CapBits-1:0] cap);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= cap;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    for (int i = 0; i < 8; i++) key_pool[i] = $urandom;
  endtask

  task automatic random_phase(int items);
    int burst;
    logic [31:0] k;
    burst = $urandom_range(1, 12);
    for (int n = 0; n < items; n++) begin
      k = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, 7)];
      send_item(logic'($urandom_range(0, 1)), k, $urandom);
      if (--burst == 0) begin
        if ($urandom_range(0, 1)) pause_sender();
        burst = $urandom_range(1, 12);
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_req_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    hold_off = 1'b0;
    stall_free = 1'b0;
    for (int i = 0; i < 8; i++) key_pool[i] = $urandom;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(OpGet, 32'h8000_0000, 32'h0);
    send_item(OpSet, 32'h8000_0000, 32'h7fff_ffff);
    send_item(OpSet, 32'h7fff_ffff, 32'h8000_0000);
    send_item(OpSet, 32'hffff_ffff, 32'hffff_ffff);
    send_item(OpSet, 32'h0, 32'h0);
    send_item(OpGet, 32'h8000_0000, 32'h1234);
    send_item(OpSet, 32'h7fff_ffff, 32'h5555_aaaa);
    send_item(OpGet, 32'h7fff_ffff, 32'h0);
    write_capacity(CapBits'(2));
    send_item(OpSet, 32'h11, 32'h1);
    send_item(OpSet, 32'h22, 32'h2);
    send_item(OpGet, 32'h0, 32'h0);
    write_capacity(CapBits'(0));
    send_item(OpSet, 32'h33, 32'h3);
    send_item(OpGet, 32'h7fff_ffff, 32'h0);
    write_capacity(CapBits'(31));
    for (int i = 0; i < 18; i++) send_item(OpSet, 32'(i + 100), 32'(i));
    write_capacity(CapBits'(1));
    send_item(OpSet, 32'h44, 32'h4);
    send_item(OpSet, 32'h55, 32'h5);

    write_capacity(CapBits'(16));
    hold_off <= 1'b1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        hold_off <= 1'b0;
      end
      random_phase(30);
    join
    stall_free <= 1'b1;
    random_phase(80);
    stall_free <= 1'b0;
    random_phase(140);
    write_capacity(CapBits'(4));
    random_phase(150);
    write_capacity(CapBits'(0));
    random_phase(30);
    write_capacity(CapBits'(1));
    random_phase(80);
    write_capacity(CapBits'(17));
    random_phase(100);
    write_capacity(CapBits'($urandom_range(2, 15)));
    random_phase(140);

    drain();
    if (fail_count == 0) begin
      $display("** lfu_cache_replacement: PASSED **");
    end else begin
      $display("** lfu_cache_replacement: FAILED **");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/lfu_pkg.sv
hw/rtl/lfu_ram.sv
hw/rtl/lfu_cache_replacement.sv
test/lfu_cache_checker.sv
test/tb_lfu_cache_replacement.sv
